[rtl/gmdt_pkg.sv]
// gmdt_pkg: shared constants, types and codes of the gradient magnitude threshold block
// used by gmdt_mul, gmdt_div, gmdt_sqrt and gradient_magnitude_dynamic_threshold
// no dependencies
package gmdt_pkg;

    // frame accumulation limits
    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PIXELS);

    // field and accumulator widths
    localparam int GRAD_W   = 16;
    localparam int MAG_W    = 16;
    localparam int FACTOR_W = 16;
    localparam int THR_W    = 24;
    localparam int SUM_W    = 36;
    localparam int SQS_W    = 52;
    localparam int SQ_W     = 32;
    localparam int MEAN_W   = 20;
    localparam int EX2_W    = 40;
    localparam int SD_W     = 24;
    localparam int ACC_W    = 42;

    // shared multiplier
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // shared divider
    localparam int DIV_W   = 60;
    localparam int DEN_W   = CNT_W;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);

    // shared square root
    localparam int RAD_W  = 48;
    localparam int ROOT_W = RAD_W / 2;
    localparam logic [RAD_W-1:0] SQRT_BIT0 = RAD_W'(1) << (RAD_W - 2);

    // configuration
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FACTOR = 1'b0;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;

    // threshold saturation bounds
    localparam logic [THR_W-1:0] THR_MAX = 24'h7fffff;
    localparam logic [THR_W-1:0] THR_MIN = 24'h800000;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_MAG_WAIT,
        S_MAGSQ,
        S_ACC,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_EX2_GO,
        S_EX2_WAIT,
        S_MSQ,
        S_VAR,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SD_GO,
        S_SD_WAIT,
        S_FMUL,
        S_THR,
        S_OUT
    } t_state;

endpackage

[rtl/gmdt_mul.sv]
// gmdt_mul: shared signed multiplier with registered product
// depends on gmdt_pkg
module gmdt_mul (
    input  logic                                 i_clk,
    input  logic signed [gmdt_pkg::MUL_W-1:0]    i_a,
    input  logic signed [gmdt_pkg::MUL_W-1:0]    i_b,
    output logic signed [gmdt_pkg::PROD_W-1:0]   o_prod
);

    logic signed [gmdt_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[rtl/gmdt_div.sv]
// gmdt_div: restoring divider, one quotient bit per cycle
// depends on gmdt_pkg
module gmdt_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [gmdt_pkg::DIV_W-1:0]          i_dividend,
    input  logic [gmdt_pkg::DEN_W-1:0]          i_divisor,
    output logic [gmdt_pkg::DIV_W-1:0]          o_quot,
    output gmdt_pkg::t_unit_sts                 o_sts
);

    logic [gmdt_pkg::DIV_W-1:0]  r_quot;
    logic [gmdt_pkg::DEN_W-1:0]  r_rem;
    logic [gmdt_pkg::DEN_W-1:0]  r_den;
    logic [gmdt_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [gmdt_pkg::DEN_W:0]    w_trial;
    logic [gmdt_pkg::DEN_W:0]    w_diff;
    logic                        w_ge;

    // shift in the next dividend bit and try to subtract
    assign w_trial = {r_rem, r_quot[gmdt_pkg::DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[gmdt_pkg::DEN_W-1:0] : w_trial[gmdt_pkg::DEN_W-1:0];
                r_quot <= {r_quot[gmdt_pkg::DIV_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == gmdt_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot     = r_quot;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

[rtl/gmdt_sqrt.sv]
// gmdt_sqrt: digit-by-digit integer square root, one result bit per cycle
// depends on gmdt_pkg
module gmdt_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [gmdt_pkg::RAD_W-1:0]          i_radicand,
    output logic [gmdt_pkg::ROOT_W-1:0]         o_root,
    output gmdt_pkg::t_unit_sts                 o_sts
);

    logic [gmdt_pkg::RAD_W-1:0] r_v;
    logic [gmdt_pkg::RAD_W-1:0] r_res;
    logic [gmdt_pkg::RAD_W-1:0] r_bit;
    logic                       r_busy;
    logic                       r_done;
    logic [gmdt_pkg::RAD_W-1:0] w_trial;
    logic                       w_ge;

    assign w_trial = r_res + r_bit;
    assign w_ge    = r_v >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_radicand;
                r_res  <= '0;
                r_bit  <= gmdt_pkg::SQRT_BIT0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root     = r_res[gmdt_pkg::ROOT_W-1:0];
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

[rtl/gradient_magnitude_dynamic_threshold.sv]
// gradient_magnitude_dynamic_threshold: per-pixel gradient magnitude and end-of-frame
// mean plus scaled deviation threshold; top level with sequencer and config port
// depends on gmdt_pkg, gmdt_mul, gmdt_div, gmdt_sqrt
//
// usage
//   input channel (i_valid / o_ready) carries one pixel gradient pair and a last flag
//   output channel (o_valid / i_ready) returns one result per pixel: the magnitude,
//   and on the last pixel of a frame the threshold with o_threshold_valid set
//   stddev_factor is written through the apb-style port at byte address 0; the user must
//   write it only while the block is idle, the block does not enforce it; pready is always high
// structure
//   one shared multiplier, one bit-serial divider and one bit-serial square root
//   are stepped by the sequencer below
//   an ordinary pixel goes through two squares, the root, the magnitude square and
//   the accumulate from transfer in to result ready
//   a last pixel adds three divisions, a second root and two multiply steps;
//   o_ready is high only while the sequencer is idle
// reset and stall
//   reset clears the frame accumulators and sets stddev_factor to 1.0 (256)
//   results sit in an output register; a new pixel is taken while it waits, and
//   the sequencer holds its finished result until the output register frees up
module gradient_magnitude_dynamic_threshold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // pixel input channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [gmdt_pkg::GRAD_W-1:0]     i_grad_x,
    input  logic signed [gmdt_pkg::GRAD_W-1:0]     i_grad_y,
    input  logic                                   i_last_pixel,
    // result output channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [gmdt_pkg::MAG_W-1:0]             o_magnitude,
    output logic signed [gmdt_pkg::THR_W-1:0]      o_threshold,
    output logic                                   o_threshold_valid,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [gmdt_pkg::PADDR_W-1:0]           paddr,
    input  logic [gmdt_pkg::PDATA_W-1:0]           pwdata,
    output logic [gmdt_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    gmdt_pkg::t_state r_state;
    gmdt_pkg::t_state n_state;

    // config register
    logic [gmdt_pkg::FACTOR_W-1:0] r_factor;

    // latched pixel
    logic signed [gmdt_pkg::GRAD_W-1:0] r_gx;
    logic signed [gmdt_pkg::GRAD_W-1:0] r_gy;
    logic                               r_last;

    // working registers
    logic [gmdt_pkg::SQ_W-1:0]   r_sqx;
    logic [gmdt_pkg::MAG_W-1:0]  r_mag;
    logic [gmdt_pkg::MEAN_W-1:0] r_mean8;
    logic [gmdt_pkg::EX2_W-1:0]  r_ex2;
    logic [gmdt_pkg::EX2_W-1:0]  r_var;
    logic [gmdt_pkg::SD_W-1:0]   r_sd12;
    logic [gmdt_pkg::THR_W-1:0]  r_thr;

    // frame accumulators
    logic [gmdt_pkg::CNT_W-1:0] r_count;
    logic [gmdt_pkg::SUM_W-1:0] r_sum;
    logic [gmdt_pkg::SQS_W-1:0] r_sumsq;

    // output register
    logic                        r_out_valid;
    logic [gmdt_pkg::MAG_W-1:0]  r_out_mag;
    logic [gmdt_pkg::THR_W-1:0]  r_out_thr;
    logic                        r_out_tv;

    // shared unit hookup
    logic signed [gmdt_pkg::MUL_W-1:0]  w_mul_a;
    logic signed [gmdt_pkg::MUL_W-1:0]  w_mul_b;
    logic signed [gmdt_pkg::PROD_W-1:0] w_prod;
    logic                               w_div_start;
    logic [gmdt_pkg::DIV_W-1:0]         w_dividend;
    logic [gmdt_pkg::DIV_W-1:0]         w_quot;
    gmdt_pkg::t_unit_sts                w_div_sts;
    logic                               w_sqrt_start;
    logic [gmdt_pkg::RAD_W-1:0]         w_radicand;
    logic [gmdt_pkg::ROOT_W-1:0]        w_root;
    gmdt_pkg::t_unit_sts                w_sqrt_sts;

    // handshake helpers
    logic w_in_xfer;
    logic w_out_free;
    logic w_cfg_wr;

    // threshold arithmetic
    logic [gmdt_pkg::SQ_W-1:0]         w_sq;
    logic [gmdt_pkg::EX2_W-1:0]        w_msq;
    logic signed [gmdt_pkg::ACC_W-1:0] w_acc;
    logic signed [gmdt_pkg::ACC_W-17:0] w_t;
    logic [gmdt_pkg::THR_W-1:0]        w_thr_sat;

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == gmdt_pkg::REG_FACTOR);

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    gmdt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    gmdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_quot     (w_quot),
        .o_sts      (w_div_sts)
    );

    gmdt_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_radicand),
        .o_root     (w_root),
        .o_sts      (w_sqrt_sts)
    );

    // ------------------------------------------------------------------
    // datapath arithmetic
    // ------------------------------------------------------------------
    // gx^2 + gy^2, the second square arrives in the cycle after the first
    assign w_sq  = r_sqx + w_prod[gmdt_pkg::SQ_W-1:0];
    assign w_msq = w_prod[gmdt_pkg::EX2_W-1:0];

    // factor * sd12 + mean8 * 4096, then floor by 2^16 via arithmetic shift
    assign w_acc = $signed(w_prod[gmdt_pkg::ACC_W-1:0])
                 + $signed({10'b0, r_mean8, 12'b0});
    assign w_t   = w_acc[gmdt_pkg::ACC_W-1:16];

    // saturate to the signed 24-bit range
    always_comb begin
        if ((w_t[25:23] == 3'b000) || (w_t[25:23] == 3'b111)) begin
            w_thr_sat = w_t[gmdt_pkg::THR_W-1:0];
        end else if (w_t[25]) begin
            w_thr_sat = gmdt_pkg::THR_MIN;
        end else begin
            w_thr_sat = gmdt_pkg::THR_MAX;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_div_start  = 1'b0;
        w_dividend   = '0;
        w_sqrt_start = 1'b0;
        w_radicand   = '0;
        unique case (r_state)
            gmdt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = gmdt_pkg::S_SQX;
                end
            end
            gmdt_pkg::S_SQX: begin
                w_mul_a = {{9{r_gx[15]}}, r_gx};
                w_mul_b = {{9{r_gx[15]}}, r_gx};
                n_state = gmdt_pkg::S_SQY;
            end
            gmdt_pkg::S_SQY: begin
                w_mul_a = {{9{r_gy[15]}}, r_gy};
                w_mul_b = {{9{r_gy[15]}}, r_gy};
                n_state = gmdt_pkg::S_SQSUM;
            end
            gmdt_pkg::S_SQSUM: begin
                w_sqrt_start = 1'b1;
                w_radicand   = {16'b0, w_sq};
                n_state      = gmdt_pkg::S_MAG_WAIT;
            end
            gmdt_pkg::S_MAG_WAIT: begin
                if (w_sqrt_sts.done) begin
                    n_state = gmdt_pkg::S_MAGSQ;
                end
            end
            gmdt_pkg::S_MAGSQ: begin
                w_mul_a = {9'b0, r_mag};
                w_mul_b = {9'b0, r_mag};
                n_state = gmdt_pkg::S_ACC;
            end
            gmdt_pkg::S_ACC: begin
                n_state = r_last ? gmdt_pkg::S_MEAN_GO : gmdt_pkg::S_OUT;
            end
            gmdt_pkg::S_MEAN_GO: begin
                w_div_start = 1'b1;
                w_dividend  = {20'b0, r_sum, 4'b0};
                n_state     = gmdt_pkg::S_MEAN_WAIT;
            end
            gmdt_pkg::S_MEAN_WAIT: begin
                if (w_div_sts.done) begin
                    n_state = gmdt_pkg::S_EX2_GO;
                end
            end
            gmdt_pkg::S_EX2_GO: begin
                w_div_start = 1'b1;
                w_dividend  = {r_sumsq, 8'b0};
                n_state     = gmdt_pkg::S_EX2_WAIT;
            end
            gmdt_pkg::S_EX2_WAIT: begin
                if (w_div_sts.done) begin
                    n_state = gmdt_pkg::S_MSQ;
                end
            end
            gmdt_pkg::S_MSQ: begin
                w_mul_a = {5'b0, r_mean8};
                w_mul_b = {5'b0, r_mean8};
                n_state = gmdt_pkg::S_VAR;
            end
            gmdt_pkg::S_VAR: begin
                n_state = gmdt_pkg::S_VAR_GO;
            end
            gmdt_pkg::S_VAR_GO: begin
                w_div_start = 1'b1;
                w_dividend  = {12'b0, r_var, 8'b0};
                n_state     = gmdt_pkg::S_VAR_WAIT;
            end
            gmdt_pkg::S_VAR_WAIT: begin
                if (w_div_sts.done) begin
                    n_state = gmdt_pkg::S_SD_GO;
                end
            end
            gmdt_pkg::S_SD_GO: begin
                w_sqrt_start = 1'b1;
                w_radicand   = w_quot[gmdt_pkg::RAD_W-1:0];
                n_state      = gmdt_pkg::S_SD_WAIT;
            end
            gmdt_pkg::S_SD_WAIT: begin
                if (w_sqrt_sts.done) begin
                    n_state = gmdt_pkg::S_FMUL;
                end
            end
            gmdt_pkg::S_FMUL: begin
                w_mul_a = {{9{r_factor[15]}}, r_factor};
                w_mul_b = {1'b0, r_sd12};
                n_state = gmdt_pkg::S_THR;
            end
            gmdt_pkg::S_THR: begin
                n_state = gmdt_pkg::S_OUT;
            end
            gmdt_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = gmdt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gmdt_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            unique case (r_state)
                gmdt_pkg::S_IDLE: begin
                    if (w_in_xfer) begin
                        r_gx   <= i_grad_x;
                        r_gy   <= i_grad_y;
                        r_last <= i_last_pixel;
                    end
                end
                gmdt_pkg::S_SQY: begin
                    r_sqx <= w_prod[gmdt_pkg::SQ_W-1:0];
                end
                gmdt_pkg::S_MAG_WAIT: begin
                    if (w_sqrt_sts.done) begin
                        r_mag <= w_root[gmdt_pkg::MAG_W-1:0];
                    end
                end
                gmdt_pkg::S_ACC: begin
                    // pixels beyond the frame limit get a magnitude but are not counted
                    if (r_count < gmdt_pkg::MAX_COUNT) begin
                        r_count <= r_count + 1'b1;
                        r_sum   <= r_sum + {20'b0, r_mag};
                        r_sumsq <= r_sumsq + {20'b0, w_prod[gmdt_pkg::SQ_W-1:0]};
                    end
                end
                gmdt_pkg::S_MEAN_WAIT: begin
                    if (w_div_sts.done) begin
                        r_mean8 <= w_quot[gmdt_pkg::MEAN_W-1:0];
                    end
                end
                gmdt_pkg::S_EX2_WAIT: begin
                    if (w_div_sts.done) begin
                        r_ex2 <= w_quot[gmdt_pkg::EX2_W-1:0];
                    end
                end
                gmdt_pkg::S_VAR: begin
                    // population variance, clamped at zero
                    r_var <= (r_ex2 > w_msq) ? (r_ex2 - w_msq) : '0;
                end
                gmdt_pkg::S_SD_WAIT: begin
                    if (w_sqrt_sts.done) begin
                        r_sd12 <= w_root;
                    end
                end
                gmdt_pkg::S_THR: begin
                    r_thr   <= w_thr_sat;
                    r_count <= '0;
                    r_sum   <= '0;
                    r_sumsq <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == gmdt_pkg::S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_mag   <= r_mag;
                r_out_thr   <= r_last ? r_thr : '0;
                r_out_tv    <= r_last;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready           = (r_state == gmdt_pkg::S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_magnitude       = r_out_mag;
    assign o_threshold       = r_out_thr;
    assign o_threshold_valid = r_out_tv;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= gmdt_pkg::FACTOR_RESET;
        end else if (w_cfg_wr) begin
            r_factor <= pwdata[gmdt_pkg::FACTOR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == gmdt_pkg::REG_FACTOR) ? {16'b0, r_factor} : '0;
    assign pready = 1'b1;

`ifndef SYNTHESIS
    // frame count never passes the accumulation limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gmdt_pkg::MAX_COUNT)
        else $error("pixel count beyond limit");

    // divider is only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_sts.busy)
        else $error("divider started while busy");

    // square root is only started when free
    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_start |-> !w_sqrt_sts.busy)
        else $error("square root started while busy");

    // a finished result waits while the output register is occupied and stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmdt_pkg::S_OUT && r_out_valid && !i_ready)
        |=> (r_state == gmdt_pkg::S_OUT && r_out_valid))
        else $error("result dropped under stall");

    // the threshold step leaves the accumulators cleared
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmdt_pkg::S_THR) |=> (r_count == '0 && r_sum == '0))
        else $error("accumulators not cleared at end of frame");
`endif

endmodule
